// ===== design/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// shared types and constants of the 3x3 fixed-point matrix inverse unit
// ----------------------------------------------------------------------------
package mi3_pkg;

   // element format
   localparam int ELEM_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int N_ELEM  = 9;

   // internal widths of the exact arithmetic
   localparam int OPND_W  = ELEM_W + 1;        // multiplier operand
   localparam int PROD_W  = 2 * OPND_W;        // multiplier result
   localparam int ACC_W   = 2 * ELEM_W;        // one element product
   localparam int ADJ_W   = 2 * ELEM_W + 1;    // adjugate element
   localparam int DET_W   = 100;               // determinant and its magnitude
   localparam int SHIFT_W = 2 * FRAC_W + 1;    // numerator scaling
   localparam int DIV_W   = 100;               // rounded numerator
   localparam int REM_W   = DIV_W + 1;         // partial remainder
   localparam int Q_W     = ELEM_W;            // quotient bits kept

   // sequencer op counts
   localparam int N_ADJ_OPS = 18;
   localparam int N_OPS     = 24;

   localparam logic [ELEM_W-1:0] ONE_FX   = ELEM_W'(1) << FRAC_W;
   localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef elem_type [N_ELEM-1:0] mat_type;

   // queue to engine
   typedef struct packed {
      logic    valid;
      mat_type mat;
   } q2e_type;

   // engine result beat
   typedef struct packed {
      mat_type inv;
      logic    singular;
      logic    saturated;
   } rsp_type;

endpackage

// ===== design/mi3_queue.sv =====
// ----------------------------------------------------------------------------
// mi3_queue
// front part: accepts request beats into a two-entry queue for the engine
// ----------------------------------------------------------------------------
module mi3_queue import mi3_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  mat_type req_mat,
   output q2e_type q_out,
   input  logic    q_pop
);

   mat_type    store_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   // handshake
   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (cnt_ff != 2'd0);

   assign q_out.valid = (cnt_ff != 2'd0);
   assign q_out.mat   = store_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= req_mat;
      end
   end

endmodule

// ===== design/mi3_engine.sv =====
// ----------------------------------------------------------------------------
// mi3_engine
// back part: adjugate and determinant on one shared multiplier, then a
// radix-2 restoring divide per element, rounding and saturation
// ----------------------------------------------------------------------------
module mi3_engine import mi3_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  q2e_type q_in,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_out
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_SETUP = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   localparam logic [4:0] LAST_OP   = 5'(N_OPS - 1);
   localparam logic [4:0] ADJ_OPS   = 5'(N_ADJ_OPS);
   localparam logic [3:0] LAST_ELEM = 4'(N_ELEM - 1);
   localparam logic [4:0] LAST_BIT  = 5'(Q_W - 1);

   logic [2:0]               state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mat_type                  mat_ff, mat_in;
   logic [4:0]               op_ff, op_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ADJ_W-1:0]  adj_ff [N_ELEM];
   logic signed [ADJ_W-1:0]  adj_in [N_ELEM];
   logic signed [DET_W-1:0]  det_ff, det_in;
   logic [DET_W-1:0]         dmag_ff, dmag_in;
   logic [DIV_W-1:0]         d2_ff, d2_in;
   logic                     detneg_ff, detneg_in;
   logic [3:0]               elem_ff, elem_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [Q_W-1:0]           nlo_ff, nlo_in;
   logic [Q_W-1:0]           quo_ff, quo_in;
   logic [4:0]               count_ff, count_in;
   logic                     big_ff, big_in;
   logic                     neg_ff, neg_in;
   mat_type                  res_ff, res_in;
   logic                     sing_ff, sing_in;
   logic                     sat_ff, sat_in;
   rsp_type                  out_ff, out_in;

   logic signed [OPND_W-1:0] opa, opb;
   logic [3:0]               adj_rd_idx;
   logic [4:0]               det_op;
   logic signed [ADJ_W-1:0]  adj_rd;
   logic [ACC_W-1:0]         amag;
   logic [DIV_W-1:0]         n_full;
   logic [REM_W-1:0]         rs;
   logic                     neg_eff, over;
   logic [Q_W-1:0]           mag, val;

   // adjugate read address: determinant ops walk row 0, divide walks all
   assign det_op     = op_ff - ADJ_OPS;
   assign adj_rd_idx = (op_ff >= ADJ_OPS) ? {1'b0, det_op[3:1]} : elem_ff;
   assign adj_rd     = adj_ff[adj_rd_idx];

   // multiplier operand select
   always_comb begin
      opa = '0;
      opb = '0;
      case (op_ff)
         5'd0:  begin opa = OPND_W'(mat_ff[4]); opb = OPND_W'(mat_ff[8]); end
         5'd1:  begin opa = OPND_W'(mat_ff[7]); opb = OPND_W'(mat_ff[5]); end
         5'd2:  begin opa = OPND_W'(mat_ff[7]); opb = OPND_W'(mat_ff[2]); end
         5'd3:  begin opa = OPND_W'(mat_ff[1]); opb = OPND_W'(mat_ff[8]); end
         5'd4:  begin opa = OPND_W'(mat_ff[1]); opb = OPND_W'(mat_ff[5]); end
         5'd5:  begin opa = OPND_W'(mat_ff[4]); opb = OPND_W'(mat_ff[2]); end
         5'd6:  begin opa = OPND_W'(mat_ff[5]); opb = OPND_W'(mat_ff[6]); end
         5'd7:  begin opa = OPND_W'(mat_ff[8]); opb = OPND_W'(mat_ff[3]); end
         5'd8:  begin opa = OPND_W'(mat_ff[8]); opb = OPND_W'(mat_ff[0]); end
         5'd9:  begin opa = OPND_W'(mat_ff[2]); opb = OPND_W'(mat_ff[6]); end
         5'd10: begin opa = OPND_W'(mat_ff[2]); opb = OPND_W'(mat_ff[3]); end
         5'd11: begin opa = OPND_W'(mat_ff[5]); opb = OPND_W'(mat_ff[0]); end
         5'd12: begin opa = OPND_W'(mat_ff[3]); opb = OPND_W'(mat_ff[7]); end
         5'd13: begin opa = OPND_W'(mat_ff[6]); opb = OPND_W'(mat_ff[4]); end
         5'd14: begin opa = OPND_W'(mat_ff[6]); opb = OPND_W'(mat_ff[1]); end
         5'd15: begin opa = OPND_W'(mat_ff[0]); opb = OPND_W'(mat_ff[7]); end
         5'd16: begin opa = OPND_W'(mat_ff[0]); opb = OPND_W'(mat_ff[4]); end
         5'd17: begin opa = OPND_W'(mat_ff[3]); opb = OPND_W'(mat_ff[1]); end
         5'd18: begin
            opa = OPND_W'(mat_ff[0]);
            opb = $signed({1'b0, adj_rd[ELEM_W-1:0]});
         end
         5'd19: begin opa = OPND_W'(mat_ff[0]); opb = adj_rd[ADJ_W-1:ELEM_W]; end
         5'd20: begin
            opa = OPND_W'(mat_ff[3]);
            opb = $signed({1'b0, adj_rd[ELEM_W-1:0]});
         end
         5'd21: begin opa = OPND_W'(mat_ff[3]); opb = adj_rd[ADJ_W-1:ELEM_W]; end
         5'd22: begin
            opa = OPND_W'(mat_ff[6]);
            opb = $signed({1'b0, adj_rd[ELEM_W-1:0]});
         end
         5'd23: begin opa = OPND_W'(mat_ff[6]); opb = adj_rd[ADJ_W-1:ELEM_W]; end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   // divide datapath
   always_comb begin
      amag   = adj_rd[ADJ_W-1] ? ACC_W'(-adj_rd) : adj_rd[ACC_W-1:0];
      n_full = DIV_W'({amag, {SHIFT_W{1'b0}}}) + DIV_W'(dmag_ff);
      rs     = {rem_ff[REM_W-2:0], nlo_ff[Q_W-1]};
      // rounding, sign and clamp of the finished quotient
      neg_eff = neg_ff && (big_ff || (quo_ff != '0));
      over    = big_ff || (neg_eff ? (quo_ff > ELEM_MIN) : (quo_ff > ELEM_MAX));
      mag     = over ? (neg_eff ? ELEM_MIN : ELEM_MAX) : quo_ff;
      val     = neg_eff ? (~mag + Q_W'(1)) : mag;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      mat_in       = mat_ff;
      op_in        = op_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      adj_in       = adj_ff;
      det_in       = det_ff;
      dmag_in      = dmag_ff;
      d2_in        = d2_ff;
      detneg_in    = detneg_ff;
      elem_in      = elem_ff;
      rem_in       = rem_ff;
      nlo_in       = nlo_ff;
      quo_in       = quo_ff;
      count_in     = count_ff;
      big_in       = big_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      sing_in      = sing_ff;
      sat_in       = sat_ff;
      out_in       = out_ff;
      q_pop        = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_in.valid) begin
               q_pop    = 1'b1;
               mat_in   = q_in.mat;
               op_in    = '0;
               det_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = opa * opb;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (op_ff < ADJ_OPS) begin
               if (!op_ff[0]) begin
                  acc_in = $signed(prod_ff[ACC_W-1:0]);
               end else begin
                  adj_in[op_ff[4:1]] = ADJ_W'(acc_ff) - ADJ_W'($signed(prod_ff[ACC_W-1:0]));
               end
            end else begin
               det_in = det_ff + (op_ff[0] ? (DET_W'(prod_ff) <<< ELEM_W) : DET_W'(prod_ff));
            end
            if (op_ff == LAST_OP) begin
               state_in = ST_CHECK;
            end else begin
               op_in    = op_ff + 5'd1;
               state_in = ST_MUL;
            end
         end
         ST_CHECK: begin
            sat_in  = 1'b0;
            elem_in = '0;
            // hand the adjugate read port to the divide walk
            op_in   = '0;
            if (det_ff == '0) begin
               res_in    = '0;
               res_in[0] = ONE_FX;
               res_in[4] = ONE_FX;
               res_in[8] = ONE_FX;
               sing_in   = 1'b1;
               state_in  = ST_DONE;
            end else begin
               dmag_in   = det_ff[DET_W-1] ? DET_W'(-det_ff) : det_ff;
               d2_in     = DIV_W'({dmag_in, 1'b0});
               detneg_in = det_ff[DET_W-1];
               sing_in   = 1'b0;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            rem_in   = REM_W'(n_full[DIV_W-1:Q_W]);
            nlo_in   = n_full[Q_W-1:0];
            quo_in   = '0;
            count_in = '0;
            neg_in   = adj_rd[ADJ_W-1] ^ detneg_ff;
            big_in   = REM_W'(n_full[DIV_W-1:Q_W]) >= REM_W'(d2_ff);
            state_in = big_in ? ST_FIN : ST_DIV;
         end
         ST_DIV: begin
            if (rs >= REM_W'(d2_ff)) begin
               rem_in = rs - REM_W'(d2_ff);
               quo_in = {quo_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_in = rs;
               quo_in = {quo_ff[Q_W-2:0], 1'b0};
            end
            nlo_in   = {nlo_ff[Q_W-2:0], 1'b0};
            count_in = count_ff + 5'd1;
            if (count_ff == LAST_BIT) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            res_in[elem_ff] = val;
            sat_in          = sat_ff | over;
            if (elem_ff == LAST_ELEM) begin
               state_in = ST_DONE;
            end else begin
               elem_in  = elem_ff + 4'd1;
               state_in = ST_SETUP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_in.inv       = res_ff;
               out_in.singular  = sing_ff;
               out_in.saturated = sat_ff;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mat_ff    <= mat_in;
      op_ff     <= op_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      adj_ff    <= adj_in;
      det_ff    <= det_in;
      dmag_ff   <= dmag_in;
      d2_ff     <= d2_in;
      detneg_ff <= detneg_in;
      elem_ff   <= elem_in;
      rem_ff    <= rem_in;
      nlo_ff    <= nlo_in;
      quo_ff    <= quo_in;
      count_ff  <= count_in;
      big_ff    <= big_in;
      neg_ff    <= neg_in;
      res_ff    <= res_in;
      sing_ff   <= sing_in;
      sat_ff    <= sat_in;
      out_ff    <= out_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out   = out_ff;

endmodule

// ===== design/matrix3x3_inverse_unit.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit
// inverse of one 3x3 signed Q16.16 matrix via adjugate over determinant
// ----------------------------------------------------------------------------
// sequence: from request beat to rsp_valid the engine pops the queue, runs the
//   adjugate and determinant on the shared multiplier, checks the determinant,
//   divides each element in the one-bit-per-cycle divider and loads the output;
//   an overflowing element skips its divide; a singular matrix skips all divides
// throughput: one matrix per engine pass; a two-entry queue and the output
//   register take new beats while a result waits
// reset: synchronous; clears the queue, the sequencer and rsp_valid
module matrix3x3_inverse_unit import mi3_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_a00,
   input  logic [31:0] req_a01,
   input  logic [31:0] req_a02,
   input  logic [31:0] req_a10,
   input  logic [31:0] req_a11,
   input  logic [31:0] req_a12,
   input  logic [31:0] req_a20,
   input  logic [31:0] req_a21,
   input  logic [31:0] req_a22,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_inv00,
   output logic [31:0] rsp_inv01,
   output logic [31:0] rsp_inv02,
   output logic [31:0] rsp_inv10,
   output logic [31:0] rsp_inv11,
   output logic [31:0] rsp_inv12,
   output logic [31:0] rsp_inv20,
   output logic [31:0] rsp_inv21,
   output logic [31:0] rsp_inv22,
   output logic        rsp_singular,
   output logic        rsp_saturated
);

   mat_type req_mat;
   q2e_type q2e;
   logic    q_pop;
   rsp_type rsp;

   // request beat packing, row major
   assign req_mat[0] = req_a00;
   assign req_mat[1] = req_a01;
   assign req_mat[2] = req_a02;
   assign req_mat[3] = req_a10;
   assign req_mat[4] = req_a11;
   assign req_mat[5] = req_a12;
   assign req_mat[6] = req_a20;
   assign req_mat[7] = req_a21;
   assign req_mat[8] = req_a22;

   mi3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mat   (req_mat),
      .q_out     (q2e),
      .q_pop     (q_pop)
   );

   mi3_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q2e),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out   (rsp)
   );

   // response beat unpacking
   assign rsp_inv00     = rsp.inv[0];
   assign rsp_inv01     = rsp.inv[1];
   assign rsp_inv02     = rsp.inv[2];
   assign rsp_inv10     = rsp.inv[3];
   assign rsp_inv11     = rsp.inv[4];
   assign rsp_inv12     = rsp.inv[5];
   assign rsp_inv20     = rsp.inv[6];
   assign rsp_inv21     = rsp.inv[7];
   assign rsp_inv22     = rsp.inv[8];
   assign rsp_singular  = rsp.singular;
   assign rsp_saturated = rsp.saturated;

endmodule

// ===== design/mi3_checker.sv =====
// ----------------------------------------------------------------------------
// mi3_checker
// port-level checks of the matrix inverse unit, bound to the top level
// ----------------------------------------------------------------------------
module mi3_checker import mi3_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_inv00,
   input logic [31:0] rsp_inv01,
   input logic [31:0] rsp_inv11,
   input logic [31:0] rsp_inv22,
   input logic        rsp_singular,
   input logic        rsp_saturated
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_inv00)
         && $stable(rsp_singular) && $stable(rsp_saturated))
      else $error("stalled response beat changed");

   // singular result is the identity
   a_sing_ident: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> (rsp_inv00 == ONE_FX) && (rsp_inv11 == ONE_FX)
         && (rsp_inv22 == ONE_FX) && (rsp_inv01 == '0))
      else $error("singular result is not the identity");

   // identity is representable, so no clamp
   a_sing_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated)
      else $error("singular result flagged saturated");

   // reset empties the response side
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind matrix3x3_inverse_unit mi3_checker u_mi3_checker (.*);
